[src/u8d_pkg.sv]
// u8d_pkg: types and constants shared by the utf-8 stream decoder files
// depends on nothing; compiled first
package u8d_pkg;

    // command codes of an input beat
    localparam logic C_CMD_FEED  = 1'b0;
    localparam logic C_CMD_FLUSH = 1'b1;

    // code point width and the replacement character
    localparam int unsigned C_CP_W = 21;
    localparam logic [C_CP_W-1:0] C_REPL_CHAR = 21'h00FFFD;

    // lead byte ranges
    localparam logic [7:0] C_ASCII_TOP   = 8'h7F;
    localparam logic [7:0] C_LEAD2_LO    = 8'hC2;
    localparam logic [7:0] C_LEAD2_HI    = 8'hDF;
    localparam logic [7:0] C_LEAD3_LO    = 8'hE0;
    localparam logic [7:0] C_LEAD3_HI    = 8'hEF;
    localparam logic [7:0] C_LEAD4_LO    = 8'hF0;
    localparam logic [7:0] C_LEAD4_HI    = 8'hF4;
    localparam logic [7:0] C_LEAD_SURR   = 8'hED;

    // continuation bounds
    localparam logic [7:0] C_CONT_LO     = 8'h80;
    localparam logic [7:0] C_CONT_HI     = 8'hBF;
    localparam logic [7:0] C_E0_LO       = 8'hA0;
    localparam logic [7:0] C_ED_HI       = 8'h9F;
    localparam logic [7:0] C_F0_LO       = 8'h90;
    localparam logic [7:0] C_F4_HI       = 8'h8F;

    // one decoded result
    typedef struct packed {
        logic [C_CP_W-1:0] scalar_val;
        logic              byte_reexamined;
        logic              last;
    } t_result;

endpackage

[src/u8d_if.sv]
// u8d_if: valid/ready channels for input bytes and decoded code points
// depends on u8d_pkg
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] data_byte;

    modport source (output valid, output cmd, output data_byte, input ready);
    modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface u8d_out_if;
    logic                        valid;
    logic                        ready;
    logic [u8d_pkg::C_CP_W-1:0]  scalar_val;
    logic                        byte_reexamined;
    logic                        last;

    modport source (output valid, output scalar_val, output byte_reexamined,
                    output last, input ready);
    modport sink   (input valid, input scalar_val, input byte_reexamined,
                    input last, output ready);
endinterface

[src/utf8_stream_decoder.sv]
// utf8_stream_decoder: byte stream to unicode code points, with u+fffd replacement
// a result is registered into the result queue when its input beat is taken, then shown on o_out from the queue head
// throughput: one input beat per cycle while the queue holds two results or fewer
// the state update is a single registered pass; a byte that gives two results is absorbed by a 4-entry queue
// reset (i_rst_n low, synchronous): no sequence pending, result queue empty
// depends on u8d_pkg and u8d_if
module utf8_stream_decoder (
    input  logic             i_clk,
    input  logic             i_rst_n,
    u8d_in_if.sink           i_in,
    u8d_out_if.source        o_out
);
    import u8d_pkg::*;

    localparam int unsigned C_Q_DEPTH = 4;

    // decoder state
    logic [C_CP_W-1:0] r_pv, n_pv;
    logic [1:0]        r_bl, n_bl;
    logic [7:0]        r_lo, n_lo;
    logic [7:0]        r_hi, n_hi;

    // result queue
    t_result     r_q [C_Q_DEPTH];
    logic [1:0]  r_wr_ptr, n_wr_ptr;
    logic [1:0]  r_rd_ptr, n_rd_ptr;
    logic [2:0]  r_count, n_count;

    logic        w_accept;
    logic        w_pop;
    logic [7:0]  w_b;
    logic        w_bad;
    logic        w_lead_en;
    logic        w_lead_emit;
    logic [C_CP_W-1:0] w_lead_cp;
    logic [1:0]  w_nres;
    t_result     w_res0;
    t_result     w_res1;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_pop    = o_out.valid && o_out.ready;
    assign w_b      = i_in.data_byte;
    assign w_bad    = (w_b < r_lo) || (w_b > r_hi);

    // room for two results keeps every byte acceptable in one beat
    assign i_in.ready = (r_count <= 3'd2);

    // decode one beat into up to two results
    always_comb begin
        n_pv        = r_pv;
        n_bl        = r_bl;
        n_lo        = r_lo;
        n_hi        = r_hi;
        w_res0      = '{scalar_val: C_REPL_CHAR, byte_reexamined: 1'b0, last: 1'b1};
        w_res1      = '{scalar_val: C_REPL_CHAR, byte_reexamined: 1'b0, last: 1'b1};
        w_nres      = 2'd0;
        w_lead_en   = 1'b0;
        w_lead_emit = 1'b0;
        w_lead_cp   = C_REPL_CHAR;

        if (w_accept) begin
            if (i_in.cmd == C_CMD_FLUSH) begin
                if (r_bl != 2'd0) begin
                    n_pv   = '0;
                    n_bl   = 2'd0;
                    n_lo   = C_CONT_LO;
                    n_hi   = C_CONT_HI;
                    w_nres = 2'd1;
                end
            end else if (r_bl != 2'd0) begin
                if (w_bad) begin
                    // partial sequence dropped, byte goes back through lead decode
                    n_pv      = '0;
                    n_bl      = 2'd0;
                    n_lo      = C_CONT_LO;
                    n_hi      = C_CONT_HI;
                    w_res0    = '{scalar_val: C_REPL_CHAR, byte_reexamined: 1'b1,
                                  last: 1'b0};
                    w_nres    = 2'd1;
                    w_lead_en = 1'b1;
                end else begin
                    n_pv = {r_pv[C_CP_W-7:0], w_b[5:0]};
                    n_bl = r_bl - 2'd1;
                    n_lo = C_CONT_LO;
                    n_hi = C_CONT_HI;
                    if (n_bl == 2'd0) begin
                        w_res0 = '{scalar_val: n_pv, byte_reexamined: 1'b0, last: 1'b1};
                        w_nres = 2'd1;
                        n_pv   = '0;
                    end
                end
            end else begin
                w_lead_en = 1'b1;
            end
        end

        // lead byte decode, state seen as cleared
        if (w_lead_en) begin
            if (w_b <= C_ASCII_TOP) begin
                w_lead_emit = 1'b1;
                w_lead_cp   = {{(C_CP_W-8){1'b0}}, w_b};
            end else if (w_b >= C_LEAD2_LO && w_b <= C_LEAD2_HI) begin
                n_pv = {{(C_CP_W-5){1'b0}}, w_b[4:0]};
                n_bl = 2'd1;
                n_lo = C_CONT_LO;
                n_hi = C_CONT_HI;
            end else if (w_b >= C_LEAD3_LO && w_b <= C_LEAD3_HI) begin
                n_pv = {{(C_CP_W-4){1'b0}}, w_b[3:0]};
                n_bl = 2'd2;
                n_lo = (w_b == C_LEAD3_LO) ? C_E0_LO : C_CONT_LO;
                n_hi = (w_b == C_LEAD_SURR) ? C_ED_HI : C_CONT_HI;
            end else if (w_b >= C_LEAD4_LO && w_b <= C_LEAD4_HI) begin
                n_pv = {{(C_CP_W-3){1'b0}}, w_b[2:0]};
                n_bl = 2'd3;
                n_lo = (w_b == C_LEAD4_LO) ? C_F0_LO : C_CONT_LO;
                n_hi = (w_b == C_LEAD4_HI) ? C_F4_HI : C_CONT_HI;
            end else begin
                w_lead_emit = 1'b1;
                w_lead_cp   = C_REPL_CHAR;
            end

            if (w_lead_emit) begin
                if (w_nres == 2'd0) begin
                    w_res0 = '{scalar_val: w_lead_cp, byte_reexamined: 1'b0, last: 1'b1};
                end else begin
                    w_res1 = '{scalar_val: w_lead_cp, byte_reexamined: 1'b0, last: 1'b1};
                end
                w_nres = w_nres + 2'd1;
            end else if (w_nres == 2'd1) begin
                // bad continuation opened a new sequence: replacement is the final result
                w_res0.last = 1'b1;
            end
        end
    end

    // queue pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr + w_nres;
        n_rd_ptr = r_rd_ptr + {1'b0, w_pop};
        n_count  = r_count + {1'b0, w_nres} - {2'b00, w_pop};
    end

    // decoder state and queue control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= '0;
            r_bl     <= 2'd0;
            r_lo     <= C_CONT_LO;
            r_hi     <= C_CONT_HI;
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_pv     <= n_pv;
            r_bl     <= n_bl;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue payload, written in order
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < C_Q_DEPTH; i++) begin
            if (w_nres != 2'd0 && 2'(i) == r_wr_ptr) begin
                r_q[i] <= w_res0;
            end else if (w_nres == 2'd2 && 2'(i) == (r_wr_ptr + 2'd1)) begin
                r_q[i] <= w_res1;
            end
        end
    end

    // output beat from the queue head
    assign o_out.valid           = (r_count != 3'd0);
    assign o_out.scalar_val      = r_q[r_rd_ptr].scalar_val;
    assign o_out.byte_reexamined = r_q[r_rd_ptr].byte_reexamined;
    assign o_out.last            = r_q[r_rd_ptr].last;

    // queue never overfills
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(C_Q_DEPTH))
        else $error("result queue overfilled");

    // no sequence pending means default continuation bounds
    a_idle_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bl == 2'd0) |-> (r_lo == C_CONT_LO && r_hi == C_CONT_HI))
        else $error("bounds left narrowed with no sequence pending");

    // a flush always ends any pending sequence
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.cmd == C_CMD_FLUSH) |=> (r_bl == 2'd0))
        else $error("sequence still pending after flush");

    // pointer distance agrees with fill count
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[1:0] == (r_wr_ptr - r_rd_ptr))
        else $error("queue pointers disagree with fill count");

endmodule
